// ===== rtl/core/fapd_pkg.sv =====
// Shared types and constants for the fragment-aware packet deque.
package fapd_pkg;

    // Entry store depth; must be a power of two so the ring indexes wrap naturally.
    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W      = 16;
    localparam int BYTES_W   = 16;
    localparam int TS_W      = 32;
    localparam int SEQ_W     = 32;
    localparam int FRAG_W    = 10;
    localparam int LIMIT_W   = 24;
    localparam int OCC_W     = 22;
    localparam int QLEN_W    = 7;
    localparam int REM_W     = FRAG_W + 1;
    localparam int PROD_W    = REM_W + BYTES_W;
    localparam int NEED_W    = PROD_W + 1;
    localparam int ENTRY_W   = ID_W + BYTES_W + TS_W;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic [TS_W-1:0]    ts;
    } entry_t;

    typedef struct packed {
        logic               push;
        logic               full;
        logic               frag_am;
        logic [BYTES_W-1:0] bytes;
        logic [SEQ_W-1:0]   main_seq;
        logic [FRAG_W-1:0]  frag_seq;
        logic [FRAG_W-1:0]  last_frag_seq;
        logic [OCC_W-1:0]   occ;
    } adm_req_t;

endpackage

// ===== rtl/core/fapd_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module fapd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/core/fapd_admit.sv =====
// Byte-limit admission check and refused-sequence record.
module fapd_admit import fapd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  adm_req_t           req,
    input  logic [LIMIT_W-1:0] byte_limit,
    output logic               admitted
);

    logic [REM_W-1:0]  remaining;
    logic [PROD_W-1:0] prod;
    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] single_need;
    logic [NEED_W-1:0] limit_ext;
    logic              fits;
    logic              single_fits;
    logic              seq_hit;
    logic              frag_ok;
    logic              unlimited;
    logic              checked;
    logic              record;

    logic [SEQ_W-1:0]  rej_seq_reg;
    logic [SEQ_W-1:0]  rej_seq_next;
    logic              rej_valid_reg;
    logic              rej_valid_next;

    // Negative fragment span counts as zero.
    assign remaining = (req.last_frag_seq >= req.frag_seq)
                     ? REM_W'(req.last_frag_seq) - REM_W'(req.frag_seq) + REM_W'(1)
                     : '0;
    assign prod        = PROD_W'(remaining) * PROD_W'(req.bytes);
    assign need        = NEED_W'(prod) + NEED_W'(req.occ);
    assign single_need = NEED_W'(req.bytes) + NEED_W'(req.occ);
    assign limit_ext   = NEED_W'(byte_limit);
    assign fits        = need < limit_ext;
    assign single_fits = single_need < limit_ext;
    assign seq_hit     = rej_valid_reg && (rej_seq_reg == req.main_seq);
    assign frag_ok     = fits && !seq_hit;
    assign unlimited   = (byte_limit == '0);
    assign checked     = req.push && !req.full;
    assign admitted    = checked && (unlimited || (req.frag_am ? frag_ok : single_fits));
    assign record      = fire && checked && !unlimited && req.frag_am && !frag_ok;

    assign rej_seq_next   = record ? req.main_seq : rej_seq_reg;
    assign rej_valid_next = rej_valid_reg || record;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rej_seq_reg   <= '0;
            rej_valid_reg <= 1'b0;
        end
        else
        begin
            rej_seq_reg   <= rej_seq_next;
            rej_valid_reg <= rej_valid_next;
        end
    end

endmodule

// ===== rtl/core/fragment_aware_packet_deque.sv =====
// Top level of the fragment-aware packet deque: ring control, entry store, result register.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  operation, pkt_*, is_fragmented_am, seqs
//   out       output     out_valid/out_stall  accepted, popped_*, queue_length, ...
//   cfg       input      cfg_wr_en            cfg_wr_data (byte limit)
//
// One word per cycle while the output does not stall; a taken word is held in the execute
// stage, and its result is registered when that stage fires. The store read is registered;
// the next word's read addresses come from the ring state written in the same cycle, with bypass.
// Reset clears the ring pointers, counts and refused-sequence record; the store is not cleared.
// A stall on the output holds the result and the word in the execute stage, then stalls the input.
module fragment_aware_packet_deque import fapd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [ID_W-1:0]    pkt_id,
    input  logic [BYTES_W-1:0] pkt_bytes,
    input  logic [TS_W-1:0]    pkt_timestamp,
    input  logic               is_fragmented_am,
    input  logic [SEQ_W-1:0]   main_seq,
    input  logic [FRAG_W-1:0]  frag_seq,
    input  logic [FRAG_W-1:0]  last_frag_seq,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic               popped_valid,
    output logic [ID_W-1:0]    popped_id,
    output logic [BYTES_W-1:0] popped_bytes,
    output logic [TS_W-1:0]    popped_timestamp,
    output logic [QLEN_W-1:0]  queue_length,
    output logic [OCC_W-1:0]   occupancy_bytes,
    output logic [TS_W-1:0]    hol_timestamp
);

    // execute stage
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [ID_W-1:0]    s1_id_reg;
    logic [BYTES_W-1:0] s1_bytes_reg;
    logic [TS_W-1:0]    s1_ts_reg;
    logic               s1_frag_reg;
    logic [SEQ_W-1:0]   s1_mseq_reg;
    logic [FRAG_W-1:0]  s1_fseq_reg;
    logic [FRAG_W-1:0]  s1_lseq_reg;
    logic [IDX_W-1:0]   s1_addr_a_reg;
    logic [IDX_W-1:0]   s1_addr_b_reg;

    // ring state
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic [TS_W-1:0]    head_ts_reg;
    logic [TS_W-1:0]    head_ts_next;
    logic [LIMIT_W-1:0] limit_reg;

    // store bypass
    logic               hit_a_reg;
    logic               hit_b_reg;
    entry_t             byp_reg;

    // result register
    logic               out_valid_reg;
    logic               accepted_reg;
    logic               popped_valid_reg;
    logic [ID_W-1:0]    popped_id_reg;
    logic [BYTES_W-1:0] popped_bytes_reg;
    logic [TS_W-1:0]    popped_ts_reg;
    logic [QLEN_W-1:0]  qlen_reg;
    logic [OCC_W-1:0]   occ_out_reg;
    logic [TS_W-1:0]    hol_reg;

    logic               s1_fire;
    logic               in_fire;
    op_t                in_op;
    logic               s1_is_push;
    logic               s1_is_pop;
    logic               has_entry;
    logic               pop_ok;
    logic               admitted;
    logic               do_push;
    logic               do_pop;
    adm_req_t           adm_req;

    logic [ENTRY_W-1:0] rd_a_raw;
    logic [ENTRY_W-1:0] rd_b_raw;
    entry_t             entry_a;
    entry_t             entry_b;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   addr_a_in;
    logic [IDX_W-1:0]   addr_b_in;
    logic [IDX_W-1:0]   raddr_a;
    logic [IDX_W-1:0]   raddr_b;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;
    assign in_op    = op_t'(operation);

    assign s1_is_push = (s1_op_reg == OP_PUSH_BACK) || (s1_op_reg == OP_PUSH_FRONT);
    assign s1_is_pop  = (s1_op_reg == OP_POP_FRONT) || (s1_op_reg == OP_POP_BACK);
    assign has_entry  = (count_reg != '0);
    assign pop_ok     = s1_is_pop && has_entry;

    assign adm_req.push          = s1_is_push;
    assign adm_req.full          = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign adm_req.frag_am       = s1_frag_reg;
    assign adm_req.bytes         = s1_bytes_reg;
    assign adm_req.main_seq      = s1_mseq_reg;
    assign adm_req.frag_seq      = s1_fseq_reg;
    assign adm_req.last_frag_seq = s1_lseq_reg;
    assign adm_req.occ           = occ_reg;

    fapd_admit u_admit (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .req        (adm_req),
        .byte_limit (limit_reg),
        .admitted   (admitted)
    );

    assign do_push = s1_fire && admitted;
    assign do_pop  = s1_fire && pop_ok;

    // take the word just written when the read hit its address
    assign entry_a  = hit_a_reg ? byp_reg : entry_t'(rd_a_raw);
    assign entry_b  = hit_b_reg ? byp_reg : entry_t'(rd_b_raw);
    assign head_dec = head_reg - IDX_W'(1);

    assign wdata.id    = s1_id_reg;
    assign wdata.bytes = s1_bytes_reg;
    assign wdata.ts    = s1_ts_reg;

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        occ_next     = occ_reg;
        head_ts_next = head_ts_reg;
        we           = 1'b0;
        waddr        = head_reg + count_reg[IDX_W-1:0];
        if (do_push)
        begin
            we         = 1'b1;
            count_next = count_reg + CNT_W'(1);
            occ_next   = occ_reg + OCC_W'(s1_bytes_reg);
            if (s1_op_reg == OP_PUSH_FRONT)
            begin
                // empty queue: write at the head without moving it
                head_next    = has_entry ? head_dec : head_reg;
                waddr        = has_entry ? head_dec : head_reg;
                head_ts_next = s1_ts_reg;
            end
            else if (!has_entry)
            begin
                head_ts_next = s1_ts_reg;
            end
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
            occ_next   = occ_reg - OCC_W'(entry_a.bytes);
            if (s1_op_reg == OP_POP_FRONT)
            begin
                head_next    = head_reg + IDX_W'(1);
                head_ts_next = entry_b.ts;
            end
        end
    end

    // read addresses for the incoming word, against the ring state after this cycle
    assign addr_a_in = (in_op == OP_POP_BACK)
                     ? head_next + count_next[IDX_W-1:0] - IDX_W'(1)
                     : head_next;
    assign addr_b_in = head_next + IDX_W'(1);
    assign raddr_a   = in_fire ? addr_a_in : s1_addr_a_reg;
    assign raddr_b   = in_fire ? addr_b_in : s1_addr_b_reg;

    fapd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a_raw),
        .raddr_b (raddr_b),
        .rdata_b (rd_b_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            occ_reg       <= '0;
            limit_reg     <= '0;
            hit_a_reg     <= 1'b0;
            hit_b_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_fire || (s1_valid_reg && !s1_fire);
            out_valid_reg <= s1_fire || (out_valid_reg && out_stall);
            head_reg      <= head_next;
            count_reg     <= count_next;
            occ_reg       <= occ_next;
            hit_a_reg     <= we && (waddr == raddr_a);
            hit_b_reg     <= we && (waddr == raddr_b);
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_ts_reg <= head_ts_next;
        if (we)
        begin
            byp_reg <= wdata;
        end
        if (in_fire)
        begin
            s1_op_reg     <= in_op;
            s1_id_reg     <= pkt_id;
            s1_bytes_reg  <= pkt_bytes;
            s1_ts_reg     <= pkt_timestamp;
            s1_frag_reg   <= is_fragmented_am;
            s1_mseq_reg   <= main_seq;
            s1_fseq_reg   <= frag_seq;
            s1_lseq_reg   <= last_frag_seq;
            s1_addr_a_reg <= addr_a_in;
            s1_addr_b_reg <= addr_b_in;
        end
        if (s1_fire)
        begin
            accepted_reg     <= admitted;
            popped_valid_reg <= pop_ok;
            popped_id_reg    <= pop_ok ? entry_a.id : '0;
            popped_bytes_reg <= pop_ok ? entry_a.bytes : '0;
            popped_ts_reg    <= pop_ok ? entry_a.ts : '0;
            qlen_reg         <= QLEN_W'(count_next);
            occ_out_reg      <= occ_next;
            hol_reg          <= (count_next != '0) ? head_ts_next : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = accepted_reg;
    assign popped_valid     = popped_valid_reg;
    assign popped_id        = popped_id_reg;
    assign popped_bytes     = popped_bytes_reg;
    assign popped_timestamp = popped_ts_reg;
    assign queue_length     = qlen_reg;
    assign occupancy_bytes  = occ_out_reg;
    assign hol_timestamp    = hol_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond store depth");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (occ_reg == '0))
        else $error("byte occupancy nonzero with empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && admitted) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("admitted push did not grow the queue");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(accepted_reg && popped_valid_reg))
        else $error("result marks both a push and a pop");
`endif

endmodule
